/* hw/rtl/vrplt_pkg.sv */
`default_nettype none
package vrplt_pkg;
    localparam int NAMETABLE_BYTES = 2048;
    localparam int PATTERN_BYTES = 8192;
    localparam int SPRITE_BYTES = 256;
    localparam int PALETTE_BYTES = 32;
    localparam logic [8:0] DOTS_PER_LINE = 9'd341;
    localparam logic [8:0] VBLANK_LINE = 9'd241;
    localparam logic [8:0] LAST_LINE = 9'd261;

    localparam logic [3:0] CMD_CTRL_WR = 4'd0;
    localparam logic [3:0] CMD_MASK_WR = 4'd1;
    localparam logic [3:0] CMD_STATUS_RD = 4'd2;
    localparam logic [3:0] CMD_OAM_ADDR_WR = 4'd3;
    localparam logic [3:0] CMD_OAM_DATA_WR = 4'd4;
    localparam logic [3:0] CMD_OAM_RD = 4'd5;
    localparam logic [3:0] CMD_SCROLL_WR = 4'd6;
    localparam logic [3:0] CMD_ADDR_WR = 4'd7;
    localparam logic [3:0] CMD_DATA_WR = 4'd8;
    localparam logic [3:0] CMD_DATA_RD = 4'd9;
    localparam logic [3:0] CMD_TICK = 4'd10;
    localparam logic [3:0] CMD_PATTERN_LOAD = 4'd11;

    localparam logic [0:0] REG_MIRROR_MODE = 1'b0;

    typedef struct packed {
        logic [3:0]  command;
        logic [7:0]  value;
        logic [12:0] pattern_addr;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       frame_done;
        logic       nmi_pending;
        logic       access_error;
    } rsp_t;
endpackage
`default_nettype wire

/* hw/rtl/vrplt_cmd_if.sv */
`default_nettype none
interface vrplt_cmd_if;
    logic valid;
    logic ready;
    vrplt_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/vrplt_rsp_if.sv */
`default_nettype none
interface vrplt_rsp_if;
    logic valid;
    logic ready;
    vrplt_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/video_register_port_and_line_timer_core.sv */
`default_nettype none
// Sequence: a command is accepted in ST_IDLE, executed in ST_EXEC, and its result is
// registered and held in ST_HOLD until rsp.ready takes it.
// No new command is taken until the result of the previous one has been taken
// by the response side, after which the core returns to ST_IDLE.
// Reset: rst_n clears the state and control registers (not cmd_reg or rsp_reg); a clearing
// pass then zeroes the nametable, palette and sprite memories while no command is taken.
module video_register_port_and_line_timer_core #(
    parameter int NAMETABLE_BYTES = vrplt_pkg::NAMETABLE_BYTES,
    parameter int PATTERN_BYTES = vrplt_pkg::PATTERN_BYTES,
    parameter int SPRITE_BYTES = vrplt_pkg::SPRITE_BYTES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    vrplt_cmd_if.sink        cmd,
    vrplt_rsp_if.source      rsp
);
    localparam int NW = $clog2(NAMETABLE_BYTES);
    localparam int PW = $clog2(PATTERN_BYTES);
    localparam int SW = $clog2(SPRITE_BYTES);
    localparam int CW = NW + 1;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_HOLD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] clr_reg;
    vrplt_pkg::cmd_t cmd_reg;
    vrplt_pkg::rsp_t rsp_reg, rsp_next;
    logic mirror_reg;
    logic [7:0] control_reg, control_next, mask_reg, mask_next;
    logic vblank_reg, vblank_next, hit_reg, hit_next, nmi_reg, nmi_next;
    logic [13:0] ptr_reg, ptr_next;
    logic plat_reg, plat_next, slat_reg, slat_next;
    logic [7:0] scroll_x_reg, scroll_x_next, scroll_y_reg, scroll_y_next;
    logic [7:0] rbuf_reg, rbuf_next, spr_ptr_reg, spr_ptr_next;
    logic [7:0] spr_y_reg, spr_y_next, spr_x_reg, spr_x_next;
    logic [8:0] dot_reg, dot_next, line_reg, line_next;

    logic nt_we, pal_we, pat_we, spr_we;
    logic [NW-1:0] nt_addr;
    logic [4:0] pal_addr;
    logic [SW-1:0] spr_addr;
    logic [7:0] wdata, nt_rd, pal_rd, pat_rd, spr_rd;

    logic [13:0] a;
    logic [11:0] nidx;
    logic [1:0] tbl;
    logic [4:0] pidx;
    logic [9:0] dots;
    logic clearing, accept, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = {31'd0, mirror_reg};
    assign clearing = state_reg == ST_CLEAR;
    assign cmd.ready = state_reg == ST_IDLE;
    assign accept = cmd.valid && cmd.ready;
    assign rsp.valid = state_reg == ST_HOLD;
    assign rsp.data = rsp_reg;

    assign a = ptr_reg;
    assign tbl = a[11:10];
    always_comb
    begin
        nidx = {a[11:0]};
        if ((!mirror_reg && tbl[1]) || (mirror_reg && tbl == 2'd3))
        begin
            nidx = a[11:0] - 12'h800;
        end
        else if (mirror_reg && (tbl == 2'd1 || tbl == 2'd2))
        begin
            nidx = a[11:0] - 12'h400;
        end
        pidx = a[4:0];
        if (pidx[4] && pidx[1:0] == 2'b00)
        begin
            pidx = {1'b0, pidx[3:0]};
        end
    end

    always_comb
    begin
        nt_we = 1'b0;
        pal_we = 1'b0;
        pat_we = 1'b0;
        spr_we = 1'b0;
        wdata = 8'd0;
        nt_addr = nidx[NW-1:0];
        pal_addr = pidx;
        spr_addr = spr_ptr_reg[SW-1:0];
        if (clearing)
        begin
            nt_we = 1'b1;
            pal_we = 1'b1;
            spr_we = 1'b1;
            nt_addr = clr_reg[NW-1:0];
            pal_addr = clr_reg[4:0];
            spr_addr = clr_reg[SW-1:0];
        end
        else if (state_reg == ST_EXEC)
        begin
            wdata = cmd_reg.value;
            case (cmd_reg.command)
                vrplt_pkg::CMD_DATA_WR:
                begin
                    nt_we = a[13:12] == 2'b10;
                    pal_we = a[13:8] == 6'h3F;
                end
                vrplt_pkg::CMD_OAM_DATA_WR:
                begin
                    spr_we = 1'b1;
                end
                vrplt_pkg::CMD_PATTERN_LOAD:
                begin
                    pat_we = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    vrplt_ram #(.WIDTH(8), .DEPTH(NAMETABLE_BYTES)) u_nt (
        .clk(clk), .we(nt_we), .waddr(nt_addr), .wdata(wdata), .raddr(nt_addr),
        .rdata(nt_rd));
    vrplt_ram #(.WIDTH(8), .DEPTH(vrplt_pkg::PALETTE_BYTES)) u_pal (
        .clk(clk), .we(pal_we), .waddr(pal_addr), .wdata(wdata), .raddr(pal_addr),
        .rdata(pal_rd));
    vrplt_ram #(.WIDTH(8), .DEPTH(PATTERN_BYTES)) u_pat (
        .clk(clk), .we(pat_we), .waddr(cmd_reg.pattern_addr[PW-1:0]), .wdata(wdata),
        .raddr(a[PW-1:0]), .rdata(pat_rd));
    vrplt_ram #(.WIDTH(8), .DEPTH(SPRITE_BYTES)) u_spr (
        .clk(clk), .we(spr_we), .waddr(spr_addr), .wdata(wdata), .raddr(spr_addr),
        .rdata(spr_rd));

    always_comb
    begin
        state_next = state_reg;
        rsp_next = rsp_reg;
        control_next = control_reg;
        mask_next = mask_reg;
        vblank_next = vblank_reg;
        hit_next = hit_reg;
        nmi_next = nmi_reg;
        ptr_next = ptr_reg;
        plat_next = plat_reg;
        slat_next = slat_reg;
        scroll_x_next = scroll_x_reg;
        scroll_y_next = scroll_y_reg;
        rbuf_next = rbuf_reg;
        spr_ptr_next = spr_ptr_reg;
        spr_y_next = spr_y_reg;
        spr_x_next = spr_x_reg;
        dot_next = dot_reg;
        line_next = line_reg;
        dots = {1'b0, dot_reg} + {2'b00, cmd_reg.value};
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == CW'(NAMETABLE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_HOLD;
                rsp_next = '0;
                case (cmd_reg.command)
                    vrplt_pkg::CMD_CTRL_WR:
                    begin
                        control_next = cmd_reg.value;
                        if (!control_reg[7] && cmd_reg.value[7] && vblank_reg)
                        begin
                            nmi_next = 1'b1;
                        end
                    end
                    vrplt_pkg::CMD_MASK_WR:
                    begin
                        mask_next = cmd_reg.value;
                    end
                    vrplt_pkg::CMD_STATUS_RD:
                    begin
                        rsp_next.read_byte = {vblank_reg, hit_reg, 6'd0};
                        vblank_next = 1'b0;
                        plat_next = 1'b0;
                        slat_next = 1'b0;
                    end
                    vrplt_pkg::CMD_OAM_ADDR_WR:
                    begin
                        spr_ptr_next = cmd_reg.value;
                    end
                    vrplt_pkg::CMD_OAM_DATA_WR:
                    begin
                        if (spr_ptr_reg == 8'd0)
                        begin
                            spr_y_next = cmd_reg.value;
                        end
                        if (spr_ptr_reg == 8'd3)
                        begin
                            spr_x_next = cmd_reg.value;
                        end
                        spr_ptr_next = spr_ptr_reg + 8'd1;
                    end
                    vrplt_pkg::CMD_OAM_RD:
                    begin
                        rsp_next.read_byte = spr_rd;
                    end
                    vrplt_pkg::CMD_SCROLL_WR:
                    begin
                        if (!slat_reg)
                        begin
                            scroll_x_next = cmd_reg.value;
                        end
                        else
                        begin
                            scroll_y_next = cmd_reg.value;
                        end
                        slat_next = !slat_reg;
                    end
                    vrplt_pkg::CMD_ADDR_WR:
                    begin
                        if (!plat_reg)
                        begin
                            ptr_next = {cmd_reg.value[5:0], ptr_reg[7:0]};
                        end
                        else
                        begin
                            ptr_next = {ptr_reg[13:8], cmd_reg.value};
                        end
                        plat_next = !plat_reg;
                    end
                    vrplt_pkg::CMD_DATA_WR, vrplt_pkg::CMD_DATA_RD:
                    begin
                        ptr_next = ptr_reg + (control_reg[2] ? 14'd32 : 14'd1);
                        if (!a[13] || a[13:12] == 2'b10)
                        begin
                            if (cmd_reg.command == vrplt_pkg::CMD_DATA_RD)
                            begin
                                rsp_next.read_byte = rbuf_reg;
                                rbuf_next = a[13] ? nt_rd : pat_rd;
                            end
                            else
                            begin
                                rsp_next.access_error = !a[13];
                            end
                        end
                        else if (a[13:8] != 6'h3F)
                        begin
                            rsp_next.access_error = 1'b1;
                        end
                        else if (cmd_reg.command == vrplt_pkg::CMD_DATA_RD)
                        begin
                            rsp_next.read_byte = pal_rd;
                        end
                    end
                    vrplt_pkg::CMD_TICK:
                    begin
                        dot_next = dots[8:0];
                        if (dots >= {1'b0, vrplt_pkg::DOTS_PER_LINE})
                        begin
                            if (spr_y_reg == line_reg[7:0] && !line_reg[8]
                                && {2'b00, spr_x_reg} <= dots && mask_reg[4])
                            begin
                                hit_next = 1'b1;
                            end
                            dot_next = 9'(dots - {1'b0, vrplt_pkg::DOTS_PER_LINE});
                            line_next = line_reg + 9'd1;
                            if (line_next == vrplt_pkg::VBLANK_LINE)
                            begin
                                vblank_next = 1'b1;
                                hit_next = 1'b0;
                                if (control_reg[7])
                                begin
                                    nmi_next = 1'b1;
                                end
                            end
                            if (line_reg >= vrplt_pkg::LAST_LINE)
                            begin
                                line_next = 9'd0;
                                nmi_next = 1'b0;
                                hit_next = 1'b0;
                                vblank_next = 1'b0;
                                rsp_next.frame_done = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
                rsp_next.nmi_pending = nmi_next;
            end
            ST_HOLD:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd.data;
        end
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            mirror_reg <= 1'b0;
            control_reg <= '0;
            mask_reg <= '0;
            vblank_reg <= 1'b0;
            hit_reg <= 1'b0;
            nmi_reg <= 1'b0;
            ptr_reg <= '0;
            plat_reg <= 1'b0;
            slat_reg <= 1'b0;
            scroll_x_reg <= '0;
            scroll_y_reg <= '0;
            rbuf_reg <= '0;
            spr_ptr_reg <= '0;
            spr_y_reg <= '0;
            spr_x_reg <= '0;
            dot_reg <= '0;
            line_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + CW'(1);
            end
            if (cfg_wr && {1'b0, paddr} == {vrplt_pkg::REG_MIRROR_MODE, 2'b00})
            begin
                mirror_reg <= pwdata[0];
            end
            control_reg <= control_next;
            mask_reg <= mask_next;
            vblank_reg <= vblank_next;
            hit_reg <= hit_next;
            nmi_reg <= nmi_next;
            ptr_reg <= ptr_next;
            plat_reg <= plat_next;
            slat_reg <= slat_next;
            scroll_x_reg <= scroll_x_next;
            scroll_y_reg <= scroll_y_next;
            rbuf_reg <= rbuf_next;
            spr_ptr_reg <= spr_ptr_next;
            spr_y_reg <= spr_y_next;
            spr_x_reg <= spr_x_next;
            dot_reg <= dot_next;
            line_reg <= line_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/vrplt_ram.sv */
`default_nettype none
module vrplt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire
